/* rtl/core/section_by_address_lookup_assert.svh */
// ----------------------------------------------------------------------------
// Section lookup assertion macros
// Concurrent assertion wrappers shared by the lookup RTL. They can be compiled
// out as a group.
// ----------------------------------------------------------------------------
`ifndef SECTION_BY_ADDRESS_LOOKUP_ASSERT_SVH
`define SECTION_BY_ADDRESS_LOOKUP_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define SBAL_ASSERT_IMP(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

`define SBAL_ASSERT_NEXT(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`else

`define SBAL_ASSERT_IMP(label, ck, rs, ante, cons, msg)

`define SBAL_ASSERT_NEXT(label, ck, rs, ante, cons, msg)

`endif

`endif

/* rtl/core/sbal_pkg.sv */
// ----------------------------------------------------------------------------
// Section lookup package
// Shared widths, codes, payload structs and controller types.
// ----------------------------------------------------------------------------
`default_nettype none

package sbal_pkg;

  localparam int ADDR_W               = 32;
  localparam int INDEX_W              = 4;
  localparam int DEFAULT_REGION_COUNT = 16;

  // Nearest-region window: a best distance at or above this gives no result.
  localparam logic [ADDR_W-1:0] NEAR_LIMIT = 32'h0000_1000;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [1:0] MODE_CONTAIN = 2'd0;
  localparam logic [1:0] MODE_NEAREST = 2'd1;

  typedef struct packed {
    logic              op;
    logic [INDEX_W-1:0] entry_index;
    logic [ADDR_W-1:0]  entry_offset;
    logic [ADDR_W-1:0]  entry_length;
    logic              entry_present;
    logic [ADDR_W-1:0]  query_address;
    logic [1:0]         search_mode;
  } req_t;

  typedef struct packed {
    logic              found;
    logic [INDEX_W-1:0] region_index;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH,
    ST_FINAL
  } state_t;

  typedef struct packed {
    logic load;
    logic start;
    logic issue;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
    logic pipe_busy;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

/* rtl/core/sbal_ctrl.sv */
// ----------------------------------------------------------------------------
// Section lookup controller
// Sequences loads, the slot scan, pipeline drain and the result write.
// ----------------------------------------------------------------------------
`default_nettype none

`include "section_by_address_lookup_assert.svh"

module sbal_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  input  wire logic          req_op,
  output logic               req_ready,
  input  wire sbal_pkg::sts_t sts,
  output sbal_pkg::cmd_t     cmd
);

  import sbal_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid && (req_op == OP_QUERY)) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts.scan_last) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!sts.pipe_busy) begin
          state_next = ST_FINAL;
        end
      end
      ST_FINAL: begin
        if (sts.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    req_ready  = 1'b0;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        cmd.load  = req_valid && (req_op == OP_LOAD);
        cmd.start = req_valid && (req_op == OP_QUERY);
      end
      ST_SCAN: begin
        cmd.issue = 1'b1;
      end
      ST_FLUSH: begin
        cmd = '0;
      end
      ST_FINAL: begin
        cmd.finish = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  `SBAL_ASSERT_NEXT(a_query_blocks_input, clk, rst,
    req_valid && req_ready && (req_op == OP_QUERY), !req_ready,
    "input still open after a query was taken")
  `SBAL_ASSERT_IMP(a_finish_has_room, clk, rst, cmd.finish, sts.out_free,
    "result written while the output register is held")
  `SBAL_ASSERT_IMP(a_load_only_when_idle, clk, rst, cmd.load,
    req_ready && (state == ST_IDLE), "load issued outside the idle state")

endmodule

`default_nettype wire

/* rtl/core/sbal_dpath.sv */
// ----------------------------------------------------------------------------
// Section lookup datapath
// Region store, scan pipeline with one compare and distance unit, best-match
// registers and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "section_by_address_lookup_assert.svh"

module sbal_dpath #(
  parameter int REGION_COUNT = sbal_pkg::DEFAULT_REGION_COUNT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_wr_en,
  input  wire logic [sbal_pkg::ADDR_W-1:0]   cfg_wr_data,
  input  wire sbal_pkg::req_t                req,
  input  wire sbal_pkg::cmd_t                cmd,
  output sbal_pkg::sts_t                     sts,
  output logic                               rsp_valid,
  input  wire logic                          rsp_ready,
  output sbal_pkg::rsp_t                     rsp
);

  import sbal_pkg::*;

  localparam int IDX_W = (REGION_COUNT > 1) ? $clog2(REGION_COUNT) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(REGION_COUNT - 1);

  logic [ADDR_W-1:0] linked_base;

  // Each word holds the start offset and the end offset (offset plus length).
  logic [2*ADDR_W-1:0] region_mem [REGION_COUNT];
  logic [REGION_COUNT-1:0] region_valid;

  logic             load_in_range;
  logic [IDX_W-1:0] wr_addr;

  logic [ADDR_W-1:0] qaddr;
  logic [1:0]        qmode;
  logic [IDX_W-1:0]  scan_idx;

  logic                v1;
  logic                pres1;
  logic [IDX_W-1:0]    idx1;
  logic [2*ADDR_W-1:0] rd_word;

  logic              v2;
  logic [IDX_W-1:0]  idx2;
  logic [ADDR_W-1:0] start2;
  logic [ADDR_W-1:0] end2;

  logic              ge_start;
  logic              lt_end;
  logic              v3;
  logic [IDX_W-1:0]  idx3;
  logic              contain3;
  logic [ADDR_W-1:0] dist3;

  logic [ADDR_W-1:0] best;
  logic              have;
  logic [IDX_W-1:0]  pick;
  logic              final_found;

  assign load_in_range = int'(req.entry_index) < REGION_COUNT;
  assign wr_addr       = IDX_W'(req.entry_index);

  always_ff @(posedge clk) begin
    if (rst) begin
      linked_base <= '0;
    end else if (cfg_wr_en) begin
      linked_base <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && load_in_range) begin
      region_mem[wr_addr] <= {req.entry_offset, req.entry_offset + req.entry_length};
    end
    rd_word <= region_mem[scan_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      region_valid <= '0;
    end else if (cmd.load && load_in_range) begin
      region_valid[wr_addr] <= req.entry_present;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      qaddr <= req.query_address;
      qmode <= req.search_mode;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
    end else if (cmd.start) begin
      scan_idx <= '0;
    end else if (cmd.issue) begin
      scan_idx <= (scan_idx == LAST_IDX) ? '0 : scan_idx + 1'b1;
    end
  end

  // Stage 1: slot read.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= cmd.issue;
    end
  end

  always_ff @(posedge clk) begin
    pres1 <= region_valid[scan_idx];
    idx1  <= scan_idx;
  end

  // Stage 2: region bounds, two independent adds.
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1 && pres1;
    end
  end

  always_ff @(posedge clk) begin
    idx2   <= idx1;
    start2 <= linked_base + rd_word[2*ADDR_W-1:ADDR_W];
    end2   <= linked_base + rd_word[ADDR_W-1:0];
  end

  // Stage 3: containment and distance.
  assign ge_start = qaddr >= start2;
  assign lt_end   = qaddr < end2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    idx3     <= idx2;
    contain3 <= ge_start && lt_end;
    if (!ge_start) begin
      dist3 <= start2 - qaddr;
    end else if (lt_end) begin
      dist3 <= '0;
    end else begin
      dist3 <= qaddr - end2 + 1'b1;
    end
  end

  // Stage 4: running choice.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      best <= '1;
      have <= 1'b0;
      pick <= '0;
    end else if (v3) begin
      case (qmode)
        MODE_CONTAIN: begin
          if (contain3) begin
            have <= 1'b1;
            pick <= idx3;
          end
        end
        MODE_NEAREST: begin
          if (dist3 < best) begin
            best <= dist3;
            have <= 1'b1;
            pick <= idx3;
          end else if (dist3 == best) begin
            have <= 1'b0;
            pick <= '0;
          end
        end
        default: begin
          have <= 1'b0;
        end
      endcase
    end
  end

  assign final_found = have && !((qmode == MODE_NEAREST) && (best >= NEAR_LIMIT));

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.finish) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      rsp.found        <= final_found;
      rsp.region_index <= final_found ? INDEX_W'(pick) : '0;
    end
  end

  assign sts.scan_last = scan_idx == LAST_IDX;
  assign sts.pipe_busy = v1 || v2 || v3;
  assign sts.out_free  = !rsp_valid || rsp_ready;

  `SBAL_ASSERT_NEXT(a_start_clears_scan, clk, rst, cmd.start,
    (scan_idx == '0) && !have && (best == '1),
    "query did not restart the scan")
  `SBAL_ASSERT_IMP(a_none_has_zero_index, clk, rst, rsp_valid && !rsp.found,
    rsp.region_index == '0, "empty result carries a region index")
  `SBAL_ASSERT_NEXT(a_result_held, clk, rst, rsp_valid && !rsp_ready,
    rsp_valid && $stable(rsp), "waiting result dropped or changed")

endmodule

`default_nettype wire

/* rtl/core/section_by_address_lookup.sv */
// Load transactions produce no result.
// A query walks every region slot through one compare and distance pipeline,
// and the controller returns to idle once its result is written; that write
// waits while an earlier result is still held in the output register.
// Synchronous reset empties all slots and sets the linked base to zero.
// ----------------------------------------------------------------------------
// Section by address lookup
// Region table with containment and nearest-region search over a linked base.
// ----------------------------------------------------------------------------
`default_nettype none

module section_by_address_lookup #(
  parameter int REGION_COUNT = sbal_pkg::DEFAULT_REGION_COUNT
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_wr_en,
  input  wire logic [sbal_pkg::ADDR_W-1:0] cfg_wr_data,
  input  wire logic                        req_valid,
  output logic                             req_ready,
  input  wire sbal_pkg::req_t              req,
  output logic                             rsp_valid,
  input  wire logic                        rsp_ready,
  output sbal_pkg::rsp_t                   rsp
);

  import sbal_pkg::*;

  // The controller and datapath meet only through these two bundles.
  cmd_t cmd;
  sts_t sts;

  // The controller accepts a transaction only while idle. A load transaction
  // writes its slot in the cycle it is accepted; a query transaction starts
  // a scan that issues one slot per cycle, waits for the pipeline to drain
  // and then writes the decision into the output register. The output
  // register holds a result until it is taken, so the input side reopens
  // even while an earlier result is still waiting.
  sbal_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_op    (req.op),
    .req_ready (req_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds the region store, the linked base and the scan
  // pipeline: slot read, bound computation, containment and distance, then
  // the running best choice. Region start and end are formed with 32-bit
  // wrapping arithmetic, exactly as the addresses are compared.
  sbal_dpath #(
    .REGION_COUNT (REGION_COUNT)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req         (req),
    .cmd         (cmd),
    .sts         (sts),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .rsp         (rsp)
  );

endmodule

`default_nettype wire
